[sv/frp_pkg.sv]
// Shared types and constants for the frame rotator.
// Used by the channel interfaces, the position unit, the top level and the testbench.
package frp_pkg;

  // payload and register widths
  localparam int PIXEL_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int DIM_REG_W = 9;
  localparam int ROT_W     = 2;
  localparam int FMT_W     = 3;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // default sizing of the frame store
  localparam int DEF_MAX_DIM    = 256;
  localparam int DEF_MAX_PIXELS = 65536;

  // register reset values
  localparam logic [DIM_REG_W-1:0] ROWS_RESET = 9'd256;
  localparam logic [DIM_REG_W-1:0] COLS_RESET = 9'd256;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BGR24 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BGR32 = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_ROT  = 2'd2,
    REG_FMT  = 2'd3
  } reg_e;

  typedef enum logic [ROT_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_FMT  = 2'd1,
    STAT_NOT_FULL = 2'd2
  } status_e;

endpackage

[sv/frp_if.sv]
// Valid/ready channel interfaces for command beats in and pixel beats out.
// Depends on frp_pkg for payload widths.
interface frp_in_if import frp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PIXEL_W-1:0] in_pixel;

  modport source (output valid, output cmd, output in_pixel, input ready);
  modport sink (input valid, input cmd, input in_pixel, output ready);
endinterface

interface frp_out_if import frp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [PIXEL_W-1:0]  out_pixel;
  logic                last_pixel;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output out_pixel, output last_pixel, output status,
                  input ready);
  modport sink (input valid, input out_pixel, input last_pixel, input status,
                output ready);
endinterface

[sv/frp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module frp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/frp_pos.sv]
// Output position counters and source coordinate mapping for the rotator.
// Depends on frp_pkg for the rotation codes.
module frp_pos import frp_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int EFF_W = $clog2(MAX_DIM + 1),
  localparam int POS_W = $clog2(MAX_DIM)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  rot_e             rot_i,
  input  logic [EFF_W-1:0] rows_i,
  input  logic [EFF_W-1:0] cols_i,
  output logic [POS_W-1:0] src_row_o,
  output logic [POS_W-1:0] src_col_o,
  output logic             last_o
);

  logic [POS_W-1:0] row_q, col_q, row_d, col_d;
  logic [POS_W-1:0] src_row_q, src_col_q;
  logic             last_q;

  logic             swap, wrap, is_last, col_end;
  logic [EFF_W-1:0] orows, ocols, r_e, c_e, sr_e, sc_e;
  logic [POS_W-1:0] r, c;

  always_comb begin
    // output frame shape
    swap  = (rot_i == ROT_90) || (rot_i == ROT_270);
    orows = swap ? cols_i : rows_i;
    ocols = swap ? rows_i : cols_i;

    // restart from the origin when the position fell outside the frame
    wrap = (EFF_W'(row_q) >= orows) || (EFF_W'(col_q) >= ocols);
    r    = wrap ? '0 : row_q;
    c    = wrap ? '0 : col_q;
    r_e  = EFF_W'(r);
    c_e  = EFF_W'(c);

    // source coordinate of this output pixel
    case (rot_i)
      ROT_90: begin
        sr_e = c_e;
        sc_e = cols_i - EFF_W'(1) - r_e;
      end
      ROT_180: begin
        sr_e = rows_i - EFF_W'(1) - r_e;
        sc_e = cols_i - EFF_W'(1) - c_e;
      end
      ROT_270: begin
        sr_e = rows_i - EFF_W'(1) - c_e;
        sc_e = r_e;
      end
      default: begin
        sr_e = r_e;
        sc_e = c_e;
      end
    endcase

    // raster advance
    col_end = (c_e == ocols - EFF_W'(1));
    is_last = (r_e == orows - EFF_W'(1)) && col_end;
    if (is_last) begin
      row_d = '0;
      col_d = '0;
    end else if (col_end) begin
      row_d = r + POS_W'(1);
      col_d = '0;
    end else begin
      row_d = r;
      col_d = c + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      last_q <= 1'b0;
    end else if (advance_i) begin
      row_q  <= row_d;
      col_q  <= col_d;
      last_q <= is_last;
    end
  end

  // latched source coordinate for the address stage
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      src_row_q <= POS_W'(sr_e);
      src_col_q <= POS_W'(sc_e);
    end
  end

  assign src_row_o = src_row_q;
  assign src_col_o = src_col_q;
  assign last_o    = last_q;

endmodule

[sv/frame_rotate_90_steps_top.sv]
// Frame rotator top level: config registers, command sequencer, frame store, output register.
// Depends on frp_pkg, frp_if, frp_ram and frp_pos.
//
// Load beats write the source frame in raster order into a single frame store RAM; each
// fetch beat returns the next pixel of the frame turned by 0, 90, 180 or 270 degrees.
// One beat is worked on at a time: a load goes through accept and store write; a fetch
// goes through accept, position update, address multiply-add plus RAM read, and RAM data
// to output register; a fetch answered with a status goes through accept and output
// register. A fetch waits at evaluation while the output register stays full. The steps
// are set by the sequencer around the registered read of the frame store. A fetch made
// before the whole frame is loaded returns status 2, one under an unsupported format
// returns status 1; the fetch of the last turned pixel re-arms the block for the next
// frame. No clearing pass is needed after reset.
module frame_rotate_90_steps_top import frp_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  frp_in_if.sink               in_i,
  frp_out_if.source            out_o
);

  localparam int EFF_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int TOT_W  = 2 * EFF_W;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int ADDR_W = $clog2(MAX_PIXELS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_READ = 4'b0100,
    ST_DATA = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [DIM_REG_W-1:0] rows_q, cols_q;
  rot_e                 rot_q;
  logic [FMT_W-1:0]     fmt_q;
  logic [TOT_W-1:0]     total_q;
  logic [CNT_W-1:0]     loaded_q, loaded_d;
  cmd_e                 cmd_q;
  logic [PIXEL_W-1:0]   pix_q;

  logic                 out_valid_q, out_last_q;
  logic [PIXEL_W-1:0]   out_pixel_q, out_pix_d;
  status_e              out_status_q, status_d;
  logic                 out_set, out_free;

  logic [EFF_W-1:0]     rows_eff, cols_eff;
  logic                 fmt_ok, fmt24, full, can_load;
  logic                 ram_we, ram_re, advance;
  logic [TOT_W-1:0]     rd_idx;
  logic [PIXEL_W-1:0]   ram_rdata;
  logic [POS_W-1:0]     src_row, src_col;
  logic                 pos_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
      rot_q  <= ROT_0;
      fmt_q  <= FMT_RGB24;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ROWS: rows_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_COLS: cols_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_ROT:  rot_q  <= rot_e'(cfg_data_i[ROT_W-1:0]);
        REG_FMT:  fmt_q  <= cfg_data_i[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions: zero counts as one, oversize clamps
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = EFF_W'(1);
    end else if (32'(rows_q) > 32'(MAX_DIM)) begin
      rows_eff = EFF_W'(MAX_DIM);
    end else begin
      rows_eff = EFF_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = EFF_W'(1);
    end else if (32'(cols_q) > 32'(MAX_DIM)) begin
      cols_eff = EFF_W'(MAX_DIM);
    end else begin
      cols_eff = EFF_W'(cols_q);
    end
  end

  // frame size, registered off the config path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= TOT_W'(rows_eff) * TOT_W'(cols_eff);
    end
  end

  // frame status
  assign fmt_ok   = fmt_q inside {FMT_RGB24, FMT_BGR24, FMT_RGB32, FMT_BGR32};
  assign fmt24    = fmt_q inside {FMT_RGB24, FMT_BGR24};
  assign full     = (32'(total_q) <= 32'(MAX_PIXELS)) && (32'(loaded_q) >= 32'(total_q));
  assign can_load = (32'(loaded_q) < 32'(total_q)) && (32'(loaded_q) < 32'(MAX_PIXELS));
  assign out_free = !out_valid_q || out_o.ready;

  // sequencer
  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    advance  = 1'b0;
    out_set  = 1'b0;
    status_d = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (cmd_q == CMD_LOAD) begin
          if (can_load) begin
            ram_we   = 1'b1;
            loaded_d = loaded_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end else if (out_free) begin
          if (!fmt_ok) begin
            out_set  = 1'b1;
            status_d = STAT_BAD_FMT;
            state_d  = ST_IDLE;
          end else if (!full) begin
            out_set  = 1'b1;
            status_d = STAT_NOT_FULL;
            state_d  = ST_IDLE;
          end else begin
            advance = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        if (pos_last) begin
          loaded_d = '0;
        end
        state_d = ST_DATA;
      end
      ST_DATA: begin
        out_set = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
    end
  end

  // command beat capture
  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= cmd_e'(in_i.cmd);
      pix_q <= in_i.in_pixel;
    end
  end

  // position counters and source mapping
  frp_pos #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rot_i     (rot_q),
    .rows_i    (rows_eff),
    .cols_i    (cols_eff),
    .src_row_o (src_row),
    .src_col_o (src_col),
    .last_o    (pos_last)
  );

  // source address multiply-add
  assign rd_idx = TOT_W'(src_row) * TOT_W'(cols_eff) + TOT_W'(src_col);

  frp_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(loaded_q)),
    .wdata_i (pix_q),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(rd_idx)),
    .rdata_o (ram_rdata)
  );

  // output register
  always_comb begin
    if (state_q == ST_DATA) begin
      out_pix_d = fmt24 ? {8'h00, ram_rdata[23:0]} : ram_rdata;
    end else begin
      out_pix_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_set) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_set) begin
      out_pixel_q  <= out_pix_d;
      out_last_q   <= (state_q == ST_DATA) && pos_last;
      out_status_q <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_pixel  = out_pixel_q;
  assign out_o.last_pixel = out_last_q;
  assign out_o.status     = out_status_q;

`ifndef SYNTHESIS
  // store writes stay inside the frame store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(loaded_q) < 32'(MAX_PIXELS)))
    else $error("frame store write beyond its depth");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_set |-> (!out_valid_q || out_o.ready))
    else $error("output register overwritten");

  // 24-bit formats return a clear upper byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_OK) && (fmt_q == FMT_RGB24 || fmt_q == FMT_BGR24))
      |-> (out_pixel_q[31:24] == 8'h00))
    else $error("upper byte set on a 24-bit pixel");

  // store data is only taken in the cycle after a read was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> $past(ram_re))
    else $error("pixel taken without a store read");
`endif

endmodule

[verif/frame_rotate_90_steps_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the frame rotator top level: drives load and fetch beats,
// predicts each rotated pixel beat and checks it. Depends on frp_pkg, frp_if and the RTL.
module frame_rotate_90_steps_top_tb import frp_pkg::*;;

  localparam int MAX_DIM        = DEF_MAX_DIM;
  localparam int MAX_PIX        = DEF_MAX_PIXELS;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int GAP_MAX        = 5;
  localparam int HOLD_CYCLES    = 50;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    status_e            status;
  } rot_pixel_t;

  // rotated frame predictor with its own copy of the store and the registers
  class frame_rotation_scoreboard;
    logic [DIM_REG_W-1:0] rows_reg;
    logic [DIM_REG_W-1:0] cols_reg;
    rot_e                 rot;
    logic [FMT_W-1:0]     fmt;
    bit [PIXEL_W-1:0]     frame_mem [MAX_PIX];
    int unsigned          loaded;
    int unsigned          out_row;
    int unsigned          out_col;
    rot_pixel_t           rotated_pixels_q [$];
    int unsigned          errors;
    int unsigned          checked;

    function new();
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      rot      = ROT_0;
      fmt      = FMT_RGB24;
      loaded   = 0;
      out_row  = 0;
      out_col  = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ROWS: rows_reg = val[DIM_REG_W-1:0];
        REG_COLS: cols_reg = val[DIM_REG_W-1:0];
        REG_ROT:  rot = rot_e'(val[ROT_W-1:0]);
        default:  fmt = val[FMT_W-1:0];
      endcase
    endfunction

    // zero counts as one, oversized counts as the largest dimension
    function int unsigned clamp_dim(logic [DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function int unsigned frame_total();
      return clamp_dim(rows_reg) * clamp_dim(cols_reg);
    endfunction

    // returns 1 when the beat does anything
    function bit predict_beat(cmd_e cmd, logic [PIXEL_W-1:0] px);
      int unsigned rows, cols, total, orows, ocols, sr, sc;
      rot_pixel_t  exp_pix;
      bit          at_end;
      rows  = clamp_dim(rows_reg);
      cols  = clamp_dim(cols_reg);
      total = rows * cols;
      // loads fill the store in raster order, extra loads are dropped
      if (cmd == CMD_LOAD) begin
        if (loaded < total && loaded < MAX_PIX) begin
          frame_mem[loaded] = px;
          loaded++;
          return 1;
        end
        return 0;
      end
      exp_pix.pixel  = '0;
      exp_pix.last   = 1'b0;
      exp_pix.status = STAT_OK;
      if (fmt > FMT_BGR32) begin
        exp_pix.status = STAT_BAD_FMT;
      end else if (total > MAX_PIX || loaded < total) begin
        exp_pix.status = STAT_NOT_FULL;
      end else begin
        if (rot == ROT_90 || rot == ROT_270) begin
          orows = cols;
          ocols = rows;
        end else begin
          orows = rows;
          ocols = cols;
        end
        // position left outside the turned frame wraps to the origin
        if (out_row >= orows || out_col >= ocols) begin
          out_row = 0;
          out_col = 0;
        end
        case (rot)
          ROT_90: begin
            sr = out_col;
            sc = cols - 1 - out_row;
          end
          ROT_180: begin
            sr = rows - 1 - out_row;
            sc = cols - 1 - out_col;
          end
          ROT_270: begin
            sr = rows - 1 - out_col;
            sc = out_row;
          end
          default: begin
            sr = out_row;
            sc = out_col;
          end
        endcase
        exp_pix.pixel = frame_mem[sr * cols + sc];
        if (fmt < FMT_RGB32) exp_pix.pixel[31:24] = 8'h00;
        at_end = (out_row == orows - 1) && (out_col == ocols - 1);
        // advance in raster order, the last pixel re-arms loading
        if (at_end) begin
          out_row = 0;
          out_col = 0;
          loaded  = 0;
        end else if (out_col == ocols - 1) begin
          out_col = 0;
          out_row++;
        end else begin
          out_col++;
        end
        exp_pix.last = at_end;
      end
      rotated_pixels_q.push_back(exp_pix);
      return 1;
    endfunction

    function void check_beat(logic [PIXEL_W-1:0] px, logic last, logic [STATUS_W-1:0] st);
      rot_pixel_t e;
      if (rotated_pixels_q.size() == 0) begin
        $error("output beat with nothing expected: out_pixel %h last_pixel %0d status %0d",
               px, last, st);
        errors++;
        return;
      end
      e = rotated_pixels_q.pop_front();
      checked++;
      if (px !== e.pixel) begin
        $error("out_pixel mismatch: expected %h, actual %h", e.pixel, px);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_pixel mismatch: expected %0d, actual %0d", e.last, last);
        errors++;
      end
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  frp_in_if  in_bus ();
  frp_out_if out_bus ();

  frame_rotation_scoreboard sb = new();

  bit          no_idle;
  bit          hold_req;
  int unsigned n_loads;
  int unsigned n_fetches;
  int unsigned n_counted;
  int unsigned n_phases;
  int unsigned quiet_cycles = 0;

  frame_rotate_90_steps_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // one command beat, with a random gap before it
  task automatic send_beat(cmd_e c, logic [PIXEL_W-1:0] px);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.cmd      <= c;
    in_bus.in_pixel <= px;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    if (sb.predict_beat(c, px)) n_counted++;
    if (c == CMD_LOAD) n_loads++;
    else n_fetches++;
    @(negedge clk_i);
  endtask

  // stop offering, wait for every pending pixel, then let a trailing load finish
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.rotated_pixels_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register writes, one per cycle, only while the block is idle
  task automatic write_config(logic [DIM_REG_W-1:0] rows, logic [DIM_REG_W-1:0] cols,
                              rot_e rot, logic [FMT_W-1:0] fmt, logic [3:0] mask);
    reg_e             idx;
    logic [CFG_W-1:0] val;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        idx = reg_e'(i);
        val = CFG_W'($urandom);
        case (idx)
          REG_ROWS: val = rows;
          REG_COLS: val = cols;
          REG_ROT:  val[ROT_W-1:0] = rot;
          default:  val[FMT_W-1:0] = fmt;
        endcase
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= idx;
        cfg_data_i <= val;
        sb.set_reg(idx, val);
        @(negedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // result sink with random stalls and an occasional long hold-off
  initial begin
    int unsigned gap;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_beat(out_bus.out_pixel, out_bus.last_pixel, out_bus.status);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned          rand_start, sel, total, n, len;
    logic [DIM_REG_W-1:0] rows, cols, big, other;
    rot_e                 rot;
    logic [FMT_W-1:0]     fmt;
    logic [3:0]           mask;
    bit                   first;

    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_ROWS;
    cfg_data_i      = '0;
    in_bus.valid    = 1'b0;
    in_bus.cmd      = CMD_LOAD;
    in_bus.in_pixel = '0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    n_loads         = 0;
    n_fetches       = 0;
    n_counted       = 0;
    n_phases        = 0;
    rst_ni          = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fetch before the frame is full under the reset sizes
    send_beat(CMD_LOAD, 32'hFFFF_FFFF);
    send_beat(CMD_FETCH, 32'h0000_0000);
    drain();

    // zero rows counts as one; loads under an unsupported format still land
    write_config(9'd0, 9'd3, ROT_0, 3'd4, 4'b1111);
    send_beat(CMD_LOAD, 32'h0000_0000);
    send_beat(CMD_LOAD, 32'hA5A5_5A5A);
    // load beyond a full frame is dropped, fetch reports the bad format
    send_beat(CMD_LOAD, 32'h1234_5678);
    send_beat(CMD_FETCH, 32'hFFFF_FFFF);
    drain();

    // 180 readout with the upper byte masked
    write_config(9'd0, 9'd3, ROT_180, FMT_RGB24, 4'b1100);
    repeat (3) send_beat(CMD_FETCH, $urandom);
    drain();

    // partial 90 readout, then a size change that pushes the position out of range
    write_config(9'd2, 9'd2, ROT_90, FMT_BGR32, 4'b1111);
    send_beat(CMD_LOAD, 32'h0000_0001);
    send_beat(CMD_LOAD, 32'h8000_0000);
    send_beat(CMD_LOAD, 32'hFFFF_FFFF);
    send_beat(CMD_LOAD, 32'h00FF_FF00);
    repeat (2) send_beat(CMD_FETCH, $urandom);
    drain();
    write_config(9'd1, 9'd2, ROT_0, FMT_BGR32, 4'b0111);
    repeat (2) send_beat(CMD_FETCH, $urandom);
    drain();

    // sizes shrunk while loading: fullness follows the new sizes
    write_config(9'd3, 9'd1, ROT_270, FMT_RGB32, 4'b1111);
    send_beat(CMD_LOAD, $urandom);
    send_beat(CMD_LOAD, $urandom);
    drain();
    write_config(9'd1, 9'd1, ROT_270, FMT_RGB32, 4'b0011);
    send_beat(CMD_FETCH, $urandom);
    drain();

    // random phases: new settings, then mostly whole frames, some noise
    rand_start = n_counted;
    while (n_counted - rand_start < RANDOM_ITEMS) begin
      first = (n_phases == 0);
      sel   = $urandom_range(0, 99);
      if (sel < 80) begin
        rows = DIM_REG_W'($urandom_range(0, 6));
        cols = DIM_REG_W'($urandom_range(0, 6));
      end else if (sel < 95) begin
        rows = DIM_REG_W'($urandom_range(1, 16));
        cols = DIM_REG_W'($urandom_range(1, 16));
      end else begin
        big   = $urandom_range(0, 1) ? 9'd256 : DIM_REG_W'($urandom_range(257, 511));
        other = DIM_REG_W'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
          rows = big;
          cols = other;
        end else begin
          rows = other;
          cols = big;
        end
      end
      rot  = rot_e'($urandom_range(0, 3));
      fmt  = ($urandom_range(0, 99) < 88) ? FMT_W'($urandom_range(0, 3))
                                          : FMT_W'($urandom_range(4, 7));
      mask = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'b11};
      if (first) begin
        rows = 9'd4;
        cols = 9'd6;
        fmt  = FMT_W'($urandom_range(0, 3));
        mask = 4'b1111;
      end
      write_config(rows, cols, rot, fmt, mask);
      no_idle = !first && ($urandom_range(0, 99) < 15);

      if (first || $urandom_range(0, 99) < 75) begin
        // well-formed frame: fill, then read out
        total = sb.frame_total();
        while (sb.loaded < total) send_beat(CMD_LOAD, $urandom);
        if ($urandom_range(0, 9) == 0) send_beat(CMD_LOAD, $urandom);
        n = total;
        if (!first && $urandom_range(0, 99) < 15) n = $urandom_range(1, total);
        // long receiver hold-off while fetches keep coming
        if (first || $urandom_range(0, 99) < 5) hold_req = 1'b1;
        repeat (n) send_beat(CMD_FETCH, $urandom);
      end else begin
        // noise: random mix of loads and fetches
        len = $urandom_range(1, 12);
        repeat (len) send_beat(cmd_e'($urandom_range(0, 1)), $urandom);
      end
      drain();
      n_phases++;
    end

    drain();
    $display("checked %0d pixel beats from %0d loads and %0d fetches", sb.checked, n_loads,
             n_fetches);
    $display("over %0d random phases of frame size, rotation and format", n_phases);
    if (sb.errors == 0 && sb.rotated_pixels_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
